FILE: hw/rtl/trrtp_pkg.sv
// Shared types, codes and default sizes for the round-robin thread picker.
`default_nettype none

package trrtp_pkg;

  // Default table geometry.
  localparam int PROCESS_COUNT_DEF       = 8;
  localparam int THREADS_PER_PROCESS_DEF = 8;

  // Fixed field widths of the channels.
  localparam int CMD_W   = 2;
  localparam int INDEX_W = 3;
  localparam int STATE_W = 2;

  // Command codes; the fourth code is unused and ignored.
  localparam logic [CMD_W-1:0] CMD_SCHEDULE    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE_STATE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SET_CURRENT = 2'd2;

  // Per-slot thread state.
  typedef enum logic [STATE_W-1:0] {
    SLOT_ABSENT  = 2'd0,
    SLOT_READY   = 2'd1,
    SLOT_RUNNING = 2'd2,
    SLOT_OTHER   = 2'd3
  } slot_state_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_DONE  = 4'b1000
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic accept;
    logic scan_step;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic scan_stop;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/trrtp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module trrtp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/trrtp_ctrl.sv
// Controller state machine of the round-robin thread picker.
`default_nettype none

module trrtp_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic [trrtp_pkg::CMD_W-1:0] in_command,
  output logic                             in_stall,
  input  wire trrtp_pkg::dp_status_t       status,
  output trrtp_pkg::dp_cmd_t               cmd
);

  import trrtp_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_stall      = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid && in_command == CMD_SCHEDULE) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_stop) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/trrtp_dp.sv
// Datapath of the round-robin thread picker: slot table, scan registers, result register.
`default_nettype none

module trrtp_dp #(
  parameter int PROCESS_COUNT       = trrtp_pkg::PROCESS_COUNT_DEF,
  parameter int THREADS_PER_PROCESS = trrtp_pkg::THREADS_PER_PROCESS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire trrtp_pkg::dp_cmd_t            cmd,
  output trrtp_pkg::dp_status_t              status,
  input  wire logic [trrtp_pkg::CMD_W-1:0]   in_command,
  input  wire logic [trrtp_pkg::INDEX_W-1:0] in_process_index,
  input  wire logic [trrtp_pkg::INDEX_W-1:0] in_thread_index,
  input  wire logic [trrtp_pkg::STATE_W-1:0] in_new_state,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_selected_valid,
  output logic      [trrtp_pkg::INDEX_W-1:0] out_selected_process,
  output logic      [trrtp_pkg::INDEX_W-1:0] out_selected_thread
);

  import trrtp_pkg::*;

  localparam int SLOT_TOTAL = PROCESS_COUNT * THREADS_PER_PROCESS;
  localparam int SLOT_W     = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1;
  localparam int PROC_W     = (PROCESS_COUNT > 1) ? $clog2(PROCESS_COUNT) : 1;
  localparam int THR_W      = (THREADS_PER_PROCESS > 1) ? $clog2(THREADS_PER_PROCESS) : 1;

  localparam logic [PROC_W-1:0] PROC_LAST  = PROC_W'(PROCESS_COUNT - 1);
  localparam logic [THR_W-1:0]  THR_LAST   = THR_W'(THREADS_PER_PROCESS - 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(SLOT_TOTAL - 1);

  function automatic logic [SLOT_W-1:0] slot_addr(input logic [PROC_W-1:0] p,
                                                  input logic [THR_W-1:0]  t);
    slot_addr = SLOT_W'(SLOT_W'(p) * SLOT_W'(THREADS_PER_PROCESS) + SLOT_W'(t));
  endfunction

  // Round-robin successor of a (process, thread) position.
  function automatic logic [PROC_W-1:0] next_proc(input logic [PROC_W-1:0] p,
                                                  input logic [THR_W-1:0]  t);
    logic [PROC_W-1:0] np;
    np = p;
    if (t == THR_LAST) begin
      np = (p == PROC_LAST) ? '0 : PROC_W'(p + 1'b1);
    end
    next_proc = np;
  endfunction

  function automatic logic [THR_W-1:0] next_thr(input logic [THR_W-1:0] t);
    next_thr = (t == THR_LAST) ? '0 : THR_W'(t + 1'b1);
  endfunction

  // Architectural position registers.
  logic [PROC_W-1:0] scan_proc_r, scan_proc_nxt;
  logic [THR_W-1:0]  scan_thr_r,  scan_thr_nxt;
  logic [PROC_W-1:0] cur_proc_r,  cur_proc_nxt;
  logic [THR_W-1:0]  cur_thr_r,   cur_thr_nxt;

  // Scan working registers.
  logic [PROC_W-1:0] probe_proc_r, probe_proc_nxt;
  logic [THR_W-1:0]  probe_thr_r,  probe_thr_nxt;
  logic [SLOT_W-1:0] steps_r,      steps_nxt;
  logic              hit_r,        hit_nxt;
  logic [SLOT_W-1:0] clr_cnt_r,    clr_cnt_nxt;

  // Result register.
  logic               out_valid_r, out_valid_nxt;
  logic               out_sel_r,   out_sel_nxt;
  logic [INDEX_W-1:0] out_proc_r,  out_proc_nxt;
  logic [INDEX_W-1:0] out_thr_r,   out_thr_nxt;

  // Table port signals.
  logic               wr_en;
  logic [SLOT_W-1:0]  wr_addr;
  logic [STATE_W-1:0] wr_data;
  logic [SLOT_W-1:0]  rd_addr;
  logic [STATE_W-1:0] rd_data_r;

  // Input decode.
  logic                in_ok;
  logic [PROC_W+2:0]   in_proc_ext;
  logic [THR_W+2:0]    in_thr_ext;
  logic [PROC_W-1:0]   in_proc;
  logic [THR_W-1:0]    in_thr;
  logic [PROC_W+2:0]   cur_proc_ext;
  logic [THR_W+2:0]    cur_thr_ext;

  slot_state_t probe_state;
  logic        probe_ready;
  logic        probe_at_cur;
  logic        scan_last;
  logic        scan_stop;

  assign in_ok = (int'(in_process_index) < PROCESS_COUNT) &&
                 (int'(in_thread_index) < THREADS_PER_PROCESS);
  assign in_proc_ext  = (PROC_W + 3)'(in_process_index);
  assign in_thr_ext   = (THR_W + 3)'(in_thread_index);
  assign in_proc      = in_proc_ext[PROC_W-1:0];
  assign in_thr       = in_thr_ext[THR_W-1:0];
  assign cur_proc_ext = (PROC_W + 3)'(cur_proc_r);
  assign cur_thr_ext  = (THR_W + 3)'(cur_thr_r);

  // The read data in a scan cycle belongs to the probe position.
  assign probe_state  = slot_state_t'(rd_data_r);
  assign probe_ready  = (probe_state == SLOT_READY);
  assign probe_at_cur = (probe_state != SLOT_ABSENT) &&
                        (probe_proc_r == cur_proc_r) && (probe_thr_r == cur_thr_r);
  assign scan_last    = (steps_r == SLOT_LAST);
  assign scan_stop    = probe_ready || probe_at_cur || scan_last;

  assign status.clr_last  = (clr_cnt_r == SLOT_LAST);
  assign status.scan_stop = scan_stop;
  assign status.out_free  = !out_valid_r || !out_stall;

  // Reads run one slot ahead of evaluation.
  always_comb begin
    if (cmd.accept) begin
      rd_addr = slot_addr(next_proc(scan_proc_r, scan_thr_r), next_thr(scan_thr_r));
    end else begin
      rd_addr = slot_addr(next_proc(probe_proc_r, probe_thr_r), next_thr(probe_thr_r));
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_cnt_r;
    wr_data = SLOT_ABSENT;
    if (cmd.clr_step) begin
      wr_en = 1'b1;
    end else if (cmd.accept && in_command == CMD_WRITE_STATE && in_ok) begin
      wr_en   = 1'b1;
      wr_addr = slot_addr(in_proc, in_thr);
      wr_data = in_new_state;
    end else if (cmd.scan_step && probe_ready) begin
      wr_en   = 1'b1;
      wr_addr = slot_addr(probe_proc_r, probe_thr_r);
      wr_data = SLOT_RUNNING;
    end
  end

  always_comb begin
    scan_proc_nxt  = scan_proc_r;
    scan_thr_nxt   = scan_thr_r;
    cur_proc_nxt   = cur_proc_r;
    cur_thr_nxt    = cur_thr_r;
    probe_proc_nxt = probe_proc_r;
    probe_thr_nxt  = probe_thr_r;
    steps_nxt      = steps_r;
    hit_nxt        = hit_r;
    clr_cnt_nxt    = clr_cnt_r;
    out_valid_nxt  = out_valid_r;
    out_sel_nxt    = out_sel_r;
    out_proc_nxt   = out_proc_r;
    out_thr_nxt    = out_thr_r;

    if (cmd.clr_step) begin
      clr_cnt_nxt = SLOT_W'(clr_cnt_r + 1'b1);
    end

    if (cmd.accept) begin
      if (in_command == CMD_SET_CURRENT && in_ok) begin
        cur_proc_nxt = in_proc;
        cur_thr_nxt  = in_thr;
      end
      probe_proc_nxt = next_proc(scan_proc_r, scan_thr_r);
      probe_thr_nxt  = next_thr(scan_thr_r);
      steps_nxt      = '0;
    end

    if (cmd.scan_step) begin
      if (scan_stop) begin
        scan_proc_nxt = probe_proc_r;
        scan_thr_nxt  = probe_thr_r;
        hit_nxt       = probe_ready;
        if (probe_ready) begin
          cur_proc_nxt = probe_proc_r;
          cur_thr_nxt  = probe_thr_r;
        end
      end else begin
        probe_proc_nxt = next_proc(probe_proc_r, probe_thr_r);
        probe_thr_nxt  = next_thr(probe_thr_r);
        steps_nxt      = SLOT_W'(steps_r + 1'b1);
      end
    end

    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
      out_sel_nxt   = hit_r;
      out_proc_nxt  = hit_r ? cur_proc_ext[INDEX_W-1:0] : '0;
      out_thr_nxt   = hit_r ? cur_thr_ext[INDEX_W-1:0] : '0;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_proc_r <= '0;
      scan_thr_r  <= '0;
      cur_proc_r  <= '0;
      cur_thr_r   <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      scan_proc_r <= scan_proc_nxt;
      scan_thr_r  <= scan_thr_nxt;
      cur_proc_r  <= cur_proc_nxt;
      cur_thr_r   <= cur_thr_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    probe_proc_r <= probe_proc_nxt;
    probe_thr_r  <= probe_thr_nxt;
    steps_r      <= steps_nxt;
    hit_r        <= hit_nxt;
    out_sel_r    <= out_sel_nxt;
    out_proc_r   <= out_proc_nxt;
    out_thr_r    <= out_thr_nxt;
  end

  trrtp_ram #(
    .WIDTH (STATE_W),
    .DEPTH (SLOT_TOTAL)
  ) u_slot_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data_r)
  );

  assign out_valid            = out_valid_r;
  assign out_selected_valid   = out_sel_r;
  assign out_selected_process = out_proc_r;
  assign out_selected_thread  = out_thr_r;

endmodule

`default_nettype wire

FILE: hw/rtl/two_level_round_robin_thread_picker_unit.sv
// Top level of the two-level round-robin thread picker.
// Write-state and set-current beats are taken in the idle state alone; a schedule beat also
// starts a scan that visits 1 to PROCESS_COUNT*THREADS_PER_PROCESS slots,
// one slot per cycle through the slot table's read port.
// After the scan the result beat waits in the final state until the result register is free.
// After reset the slot table is cleared one slot per cycle, every slot in turn.
`default_nettype none

module two_level_round_robin_thread_picker_unit #(
  parameter int PROCESS_COUNT       = trrtp_pkg::PROCESS_COUNT_DEF,
  parameter int THREADS_PER_PROCESS = trrtp_pkg::THREADS_PER_PROCESS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Command channel.
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [trrtp_pkg::CMD_W-1:0]   in_command,
  input  wire logic [trrtp_pkg::INDEX_W-1:0] in_process_index,
  input  wire logic [trrtp_pkg::INDEX_W-1:0] in_thread_index,
  input  wire logic [trrtp_pkg::STATE_W-1:0] in_new_state,
  // Result channel.
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_selected_valid,
  output logic      [trrtp_pkg::INDEX_W-1:0] out_selected_process,
  output logic      [trrtp_pkg::INDEX_W-1:0] out_selected_thread
);

  import trrtp_pkg::*;

  // The controller sequences the clearing sweep, the per-beat table updates,
  // the slot-by-slot scan and the hand-off to the result register. The
  // datapath holds the slot table, the scan and current positions and the
  // result register.
  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // The command channel is open only while the controller idles. A beat is
  // accepted whether or not a previous result still waits on the output,
  // since the result register parts the two sides. A schedule beat then
  // waits in the final state until the result register is free.
  trrtp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .status     (dp_status),
    .cmd        (dp_cmd)
  );

  // The scan reads the table one slot ahead of the slot it judges, so that
  // each cycle examines a new slot. It stops at the first ready slot, at the
  // current slot when that is present, or after one full wrap. A ready slot
  // found by the scan becomes current and is marked running in the same cycle.
  trrtp_dp #(
    .PROCESS_COUNT       (PROCESS_COUNT),
    .THREADS_PER_PROCESS (THREADS_PER_PROCESS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (dp_cmd),
    .status               (dp_status),
    .in_command           (in_command),
    .in_process_index     (in_process_index),
    .in_thread_index      (in_thread_index),
    .in_new_state         (in_new_state),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_selected_valid   (out_selected_valid),
    .out_selected_process (out_selected_process),
    .out_selected_thread  (out_selected_thread)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/trrtp_chk.sv
// Port-level checker for the round-robin thread picker and its bind statement.
`default_nettype none

module trrtp_chk (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic [trrtp_pkg::CMD_W-1:0]   in_command,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic                          out_selected_valid,
  input wire logic [trrtp_pkg::INDEX_W-1:0] out_selected_process,
  input wire logic [trrtp_pkg::INDEX_W-1:0] out_selected_thread
);

  import trrtp_pkg::*;

  // A stalled result beat stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_selected_valid) &&
    $stable(out_selected_process) && $stable(out_selected_thread))
    else $error("stalled result beat changed");

  // A result that picks nothing carries zero numbers.
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_selected_valid |->
    out_selected_process == '0 && out_selected_thread == '0)
    else $error("empty result carries a slot number");

  // The table is being cleared right after reset, so no command is taken.
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("command channel open right after reset");

  // A schedule beat keeps the block busy in the following cycle.
  a_sched_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_command == CMD_SCHEDULE |=> in_stall)
    else $error("command taken during a scan");

endmodule

bind two_level_round_robin_thread_picker_unit trrtp_chk u_trrtp_chk (.*);

`default_nettype wire
